/* rtl/core/stfs_pkg.sv */
// types, codes and reset values shared by the siren tone and flash sequencer
package stfs_pkg;

    localparam int TONE_W   = 12;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int TICK_W   = 10;
    localparam int REP_W    = 4;

    localparam int ALT_REPEATS_DEF = 3;
    localparam int FREQ_BITS_DEF   = 12;

    typedef logic [TONE_W-1:0]    tone_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [TICK_W-1:0]    tick_cnt_t;
    typedef logic [REP_W-1:0]     rep_cnt_t;
    typedef logic [1:0]           mode_t;
    typedef logic [1:0]           lights_t;

    // register indexes
    localparam cfg_idx_t CFG_SWEEP_LOW   = 3'd0;
    localparam cfg_idx_t CFG_SWEEP_HIGH  = 3'd1;
    localparam cfg_idx_t CFG_SWEEP_STEP  = 3'd2;
    localparam cfg_idx_t CFG_SWEEP_DWELL = 3'd3;
    localparam cfg_idx_t CFG_FLASH       = 3'd4;
    localparam cfg_idx_t CFG_FIRST_TONE  = 3'd5;
    localparam cfg_idx_t CFG_SECOND_TONE = 3'd6;
    localparam cfg_idx_t CFG_ALTERNATE   = 3'd7;

    // register reset values
    localparam logic [11:0] RST_SWEEP_LOW   = 12'd600;
    localparam logic [11:0] RST_SWEEP_HIGH  = 12'd1200;
    localparam logic [7:0]  RST_SWEEP_STEP  = 8'd5;
    localparam logic [7:0]  RST_SWEEP_DWELL = 8'd10;
    localparam logic [9:0]  RST_FLASH       = 10'd40;
    localparam logic [11:0] RST_FIRST_TONE  = 12'd800;
    localparam logic [11:0] RST_SECOND_TONE = 12'd1000;
    localparam logic [9:0]  RST_ALTERNATE   = 10'd100;

    // item kinds
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_COMMAND = 1'b1;

    // command characters
    localparam logic [7:0] CMD_STOP      = 8'h30;
    localparam logic [7:0] CMD_SWEEP     = 8'h31;
    localparam logic [7:0] CMD_ALTERNATE = 8'h32;

    localparam mode_t MODE_STOPPED   = 2'd0;
    localparam mode_t MODE_SWEEP     = 2'd1;
    localparam mode_t MODE_ALTERNATE = 2'd2;

    localparam lights_t LIGHTS_OFF    = 2'b00;
    localparam lights_t LIGHTS_FIRST  = 2'b01;
    localparam lights_t LIGHTS_SECOND = 2'b10;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_UP   = 4'd1,
        PH_F1A  = 4'd2,
        PH_F2A  = 4'd3,
        PH_DOWN = 4'd4,
        PH_F1B  = 4'd5,
        PH_F2B  = 4'd6,
        PH_AON  = 4'd7,
        PH_AOFF = 4'd8,
        PH_BON  = 4'd9,
        PH_BOFF = 4'd10
    } phase_t;

endpackage

/* rtl/core/siren_tone_and_flash_sequencer_core.sv */
// siren tone and flash sequencer: command decode, pattern sequencing and result register
//
// Each request on the s_ side is either a one millisecond tick (s_tuser low) or a command
// character (s_tuser high): '1' runs the rising and falling sweep with light flashes, '2'
// runs the two-tone alternate pattern, '0' stops and silences; other characters do nothing.
// A command taken while a pattern runs is held (latest wins) and applied when that pattern
// ends. Every request yields exactly one result with the tone, both lights and the selected
// mode. One request is taken per clock unless the m_ side stalls: the whole state update is
// a single registered pass, and the result appears on the m_ side the cycle after
// acceptance, held in an output register so that a new request is still taken in the cycle
// the previous result leaves. Configuration writes take effect at the next clock edge.
module siren_tone_and_flash_sequencer_core
    import stfs_pkg::*;
#(
    parameter int ALT_REPEATS = ALT_REPEATS_DEF,
    parameter int FREQ_BITS   = FREQ_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] command_byte
    input  logic        s_tuser,    // [0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [11:0] tone_hz, [12] first_light, [13] second_light,
                                    // [15:14] active_mode
    // configuration
    input  logic        cfg_wr_en,
    input  cfg_idx_t    cfg_wr_index,
    input  cfg_data_t   cfg_wr_data
);

    localparam int SUM_W = ((FREQ_BITS > CFG_W) ? FREQ_BITS : CFG_W) + 1;

    typedef logic [FREQ_BITS-1:0] freq_t;
    typedef logic [SUM_W-1:0]     sum_t;

    localparam sum_t FREQ_MAX = sum_t'((1 << FREQ_BITS) - 1);

    // configuration registers
    logic [11:0] sweep_low_reg, sweep_high_reg, first_tone_reg, second_tone_reg;
    logic [7:0]  sweep_step_reg, sweep_dwell_reg;
    logic [9:0]  flash_reg, alternate_reg;

    // sequencer state
    mode_t     selected_mode_reg, selected_mode_next;
    mode_t     pending_mode_reg, pending_mode_next;
    logic      pending_valid_reg, pending_valid_next;
    phase_t    phase_reg, phase_next;
    tick_cnt_t phase_ticks_reg, phase_ticks_next;
    freq_t     sweep_freq_reg, sweep_freq_next;
    rep_cnt_t  repeat_count_reg, repeat_count_next;
    freq_t     tone_reg, tone_next;
    lights_t   lights_reg, lights_next;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg, m_tdata_next;

    logic accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_low_reg   <= RST_SWEEP_LOW;
            sweep_high_reg  <= RST_SWEEP_HIGH;
            sweep_step_reg  <= RST_SWEEP_STEP;
            sweep_dwell_reg <= RST_SWEEP_DWELL;
            flash_reg       <= RST_FLASH;
            first_tone_reg  <= RST_FIRST_TONE;
            second_tone_reg <= RST_SECOND_TONE;
            alternate_reg   <= RST_ALTERNATE;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SWEEP_LOW:   sweep_low_reg   <= cfg_wr_data;
                CFG_SWEEP_HIGH:  sweep_high_reg  <= cfg_wr_data;
                CFG_SWEEP_STEP:  sweep_step_reg  <= cfg_wr_data[7:0];
                CFG_SWEEP_DWELL: sweep_dwell_reg <= cfg_wr_data[7:0];
                CFG_FLASH:       flash_reg       <= cfg_wr_data[9:0];
                CFG_FIRST_TONE:  first_tone_reg  <= cfg_wr_data;
                CFG_SECOND_TONE: second_tone_reg <= cfg_wr_data;
                CFG_ALTERNATE:   alternate_reg   <= cfg_wr_data[9:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        tick_cnt_t ticks_inc;
        tick_cnt_t limit;
        logic [7:0] step;
        sum_t       up_sum;
        sum_t       down_bound;
        logic       do_start;
        mode_t      start_mode;

        selected_mode_next = selected_mode_reg;
        pending_mode_next  = pending_mode_reg;
        pending_valid_next = pending_valid_reg;
        phase_next         = phase_reg;
        phase_ticks_next   = phase_ticks_reg;
        sweep_freq_next    = sweep_freq_reg;
        repeat_count_next  = repeat_count_reg;
        tone_next          = tone_reg;
        lights_next        = lights_reg;
        do_start           = 1'b0;
        start_mode         = selected_mode_reg;

        step       = (sweep_step_reg == 8'd0) ? 8'd1 : sweep_step_reg;
        up_sum     = sum_t'(sweep_freq_reg) + sum_t'(step);
        down_bound = sum_t'(sweep_low_reg) + sum_t'(step);
        ticks_inc  = phase_ticks_reg + tick_cnt_t'(1);

        case (phase_reg)
            PH_UP, PH_DOWN:                  limit = tick_cnt_t'(sweep_dwell_reg);
            PH_AON, PH_AOFF, PH_BON, PH_BOFF: limit = alternate_reg;
            default:                         limit = flash_reg;
        endcase
        if (limit == tick_cnt_t'(0)) begin
            limit = tick_cnt_t'(1);
        end

        if (accept) begin
            if (s_tuser == FUNC_TICK) begin
                if (phase_reg != PH_IDLE) begin
                    if (ticks_inc < limit) begin
                        phase_ticks_next = ticks_inc;
                    end else begin
                        phase_ticks_next = '0;
                        case (phase_reg)
                            PH_UP: begin
                                if (up_sum > sum_t'(sweep_high_reg) || up_sum > FREQ_MAX) begin
                                    lights_next = LIGHTS_FIRST;
                                    phase_next  = PH_F1A;
                                end else begin
                                    sweep_freq_next = freq_t'(up_sum);
                                    tone_next       = freq_t'(up_sum);
                                end
                            end
                            PH_DOWN: begin
                                if (sum_t'(sweep_freq_reg) < down_bound) begin
                                    lights_next = LIGHTS_FIRST;
                                    phase_next  = PH_F1B;
                                end else begin
                                    sweep_freq_next = freq_t'(sum_t'(sweep_freq_reg) -
                                                              sum_t'(step));
                                    tone_next       = sweep_freq_next;
                                end
                            end
                            PH_F1A: begin
                                lights_next = LIGHTS_SECOND;
                                phase_next  = PH_F2A;
                            end
                            PH_F1B: begin
                                lights_next = LIGHTS_SECOND;
                                phase_next  = PH_F2B;
                            end
                            PH_F2A: begin
                                lights_next     = LIGHTS_OFF;
                                sweep_freq_next = freq_t'(sweep_high_reg);
                                tone_next       = freq_t'(sweep_high_reg);
                                phase_next      = PH_DOWN;
                            end
                            PH_F2B: begin
                                do_start = 1'b1;
                            end
                            PH_AON: begin
                                lights_next = LIGHTS_OFF;
                                phase_next  = PH_AOFF;
                            end
                            PH_AOFF: begin
                                tone_next   = freq_t'(second_tone_reg);
                                lights_next = LIGHTS_SECOND;
                                phase_next  = PH_BON;
                            end
                            PH_BON: begin
                                lights_next = LIGHTS_OFF;
                                phase_next  = PH_BOFF;
                            end
                            default: begin
                                repeat_count_next = repeat_count_reg + rep_cnt_t'(1);
                                if (repeat_count_next >= rep_cnt_t'(ALT_REPEATS)) begin
                                    do_start = 1'b1;
                                end else begin
                                    tone_next   = freq_t'(first_tone_reg);
                                    lights_next = LIGHTS_FIRST;
                                    phase_next  = PH_AON;
                                end
                            end
                        endcase
                        // pattern end: a held command takes over here
                        if (do_start && pending_valid_reg) begin
                            start_mode         = pending_mode_reg;
                            pending_valid_next = 1'b0;
                            pending_mode_next  = MODE_STOPPED;
                        end
                    end
                end
            end else if (s_tdata >= CMD_STOP && s_tdata <= CMD_ALTERNATE) begin
                if (phase_reg == PH_IDLE) begin
                    start_mode = mode_t'(s_tdata - CMD_STOP);
                    do_start   = 1'b1;
                end else begin
                    pending_mode_next  = mode_t'(s_tdata - CMD_STOP);
                    pending_valid_next = 1'b1;
                end
            end
        end

        if (do_start) begin
            selected_mode_next = start_mode;
            phase_ticks_next   = '0;
            case (start_mode)
                MODE_SWEEP: begin
                    sweep_freq_next = freq_t'(sweep_low_reg);
                    tone_next       = freq_t'(sweep_low_reg);
                    lights_next     = LIGHTS_OFF;
                    phase_next      = PH_UP;
                end
                MODE_ALTERNATE: begin
                    repeat_count_next = '0;
                    tone_next         = freq_t'(first_tone_reg);
                    lights_next       = LIGHTS_FIRST;
                    phase_next        = PH_AON;
                end
                default: begin
                    tone_next   = '0;
                    lights_next = LIGHTS_OFF;
                    phase_next  = PH_IDLE;
                end
            endcase
        end
    end

    // result packing
    always_comb begin
        m_tdata_next = {selected_mode_next, lights_next[1], lights_next[0], tone_t'(tone_next)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            selected_mode_reg <= MODE_STOPPED;
            pending_mode_reg  <= MODE_STOPPED;
            pending_valid_reg <= 1'b0;
            phase_reg         <= PH_IDLE;
            phase_ticks_reg   <= '0;
            sweep_freq_reg    <= '0;
            repeat_count_reg  <= '0;
            tone_reg          <= '0;
            lights_reg        <= LIGHTS_OFF;
            m_tvalid_reg      <= 1'b0;
        end else begin
            selected_mode_reg <= selected_mode_next;
            pending_mode_reg  <= pending_mode_next;
            pending_valid_reg <= pending_valid_next;
            phase_reg         <= phase_next;
            phase_ticks_reg   <= phase_ticks_next;
            sweep_freq_reg    <= sweep_freq_next;
            repeat_count_reg  <= repeat_count_next;
            tone_reg          <= tone_next;
            lights_reg        <= lights_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// testbench for the siren sequencer: every result is predicted per request and checked in order
module tb
    import stfs_pkg::*;
;

    localparam int unsigned ITEM_BUDGET   = 1600;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned HZ_MAX        = (1 << FREQ_BITS_DEF) - 1;

    typedef struct packed {
        mode_t active_mode;
        logic  second_light;
        logic  first_light;
        tone_t tone_hz;
    } siren_result_t;

    class siren_scoreboard;
        cfg_data_t     regs [8];
        mode_t         sel_mode;
        mode_t         held_mode;
        logic          held_valid;
        phase_t        phase;
        tick_cnt_t     ticks;
        int unsigned   sweep_hz;
        rep_cnt_t      reps;
        tone_t         tone;
        lights_t       lights;
        siren_result_t expected_q [$];
        int unsigned   mismatches;

        function new();
            regs[CFG_SWEEP_LOW]   = cfg_data_t'(RST_SWEEP_LOW);
            regs[CFG_SWEEP_HIGH]  = cfg_data_t'(RST_SWEEP_HIGH);
            regs[CFG_SWEEP_STEP]  = cfg_data_t'(RST_SWEEP_STEP);
            regs[CFG_SWEEP_DWELL] = cfg_data_t'(RST_SWEEP_DWELL);
            regs[CFG_FLASH]       = cfg_data_t'(RST_FLASH);
            regs[CFG_FIRST_TONE]  = cfg_data_t'(RST_FIRST_TONE);
            regs[CFG_SECOND_TONE] = cfg_data_t'(RST_SECOND_TONE);
            regs[CFG_ALTERNATE]   = cfg_data_t'(RST_ALTERNATE);
            sel_mode   = MODE_STOPPED;
            held_mode  = MODE_STOPPED;
            held_valid = 1'b0;
            phase      = PH_IDLE;
            ticks      = '0;
            sweep_hz   = 0;
            reps       = '0;
            tone       = '0;
            lights     = LIGHTS_OFF;
            mismatches = 0;
        endfunction

        function void store_reg(cfg_idx_t idx, cfg_data_t val);
            case (idx)
                CFG_SWEEP_STEP, CFG_SWEEP_DWELL: regs[idx] = val & 12'h0FF;
                CFG_FLASH, CFG_ALTERNATE:        regs[idx] = val & 12'h3FF;
                default:                         regs[idx] = val;
            endcase
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        function void begin_pattern();
            ticks = '0;
            case (sel_mode)
                MODE_SWEEP: begin
                    sweep_hz = regs[CFG_SWEEP_LOW] & HZ_MAX;
                    tone     = tone_t'(sweep_hz);
                    lights   = LIGHTS_OFF;
                    phase    = PH_UP;
                end
                MODE_ALTERNATE: begin
                    reps   = '0;
                    tone   = regs[CFG_FIRST_TONE];
                    lights = LIGHTS_FIRST;
                    phase  = PH_AON;
                end
                default: begin
                    tone   = '0;
                    lights = LIGHTS_OFF;
                    phase  = PH_IDLE;
                end
            endcase
        endfunction

        // a held command takes over only when the running pattern completes
        function void finish_pattern();
            if (held_valid) begin
                sel_mode   = held_mode;
                held_valid = 1'b0;
                held_mode  = MODE_STOPPED;
            end
            begin_pattern();
        endfunction

        function void advance_tick();
            int unsigned span;
            int unsigned stride;
            int unsigned next_hz;
            if (phase == PH_IDLE)
                return;
            if (phase == PH_UP || phase == PH_DOWN)
                span = regs[CFG_SWEEP_DWELL];
            else if (phase >= PH_AON)
                span = regs[CFG_ALTERNATE];
            else
                span = regs[CFG_FLASH];
            if (span == 0)
                span = 1;
            ticks = ticks + 1'b1;
            if (ticks < span)
                return;
            ticks  = '0;
            stride = (regs[CFG_SWEEP_STEP] != 0) ? regs[CFG_SWEEP_STEP] : 1;
            case (phase)
                PH_UP: begin
                    next_hz = sweep_hz + stride;
                    if (next_hz > regs[CFG_SWEEP_HIGH] || next_hz > HZ_MAX) begin
                        lights = LIGHTS_FIRST;
                        phase  = PH_F1A;
                    end else begin
                        sweep_hz = next_hz;
                        tone     = tone_t'(next_hz);
                    end
                end
                PH_DOWN: begin
                    if (sweep_hz < regs[CFG_SWEEP_LOW] + stride) begin
                        lights = LIGHTS_FIRST;
                        phase  = PH_F1B;
                    end else begin
                        sweep_hz = sweep_hz - stride;
                        tone     = tone_t'(sweep_hz);
                    end
                end
                PH_F1A: begin
                    lights = LIGHTS_SECOND;
                    phase  = PH_F2A;
                end
                PH_F1B: begin
                    lights = LIGHTS_SECOND;
                    phase  = PH_F2B;
                end
                PH_F2A: begin
                    lights   = LIGHTS_OFF;
                    sweep_hz = regs[CFG_SWEEP_HIGH] & HZ_MAX;
                    tone     = tone_t'(sweep_hz);
                    phase    = PH_DOWN;
                end
                PH_F2B: begin
                    lights = LIGHTS_OFF;
                    finish_pattern();
                end
                PH_AON: begin
                    lights = LIGHTS_OFF;
                    phase  = PH_AOFF;
                end
                PH_AOFF: begin
                    tone   = regs[CFG_SECOND_TONE];
                    lights = LIGHTS_SECOND;
                    phase  = PH_BON;
                end
                PH_BON: begin
                    lights = LIGHTS_OFF;
                    phase  = PH_BOFF;
                end
                default: begin
                    reps = reps + 1'b1;
                    if (reps >= ALT_REPEATS_DEF) begin
                        finish_pattern();
                    end else begin
                        tone   = regs[CFG_FIRST_TONE];
                        lights = LIGHTS_FIRST;
                        phase  = PH_AON;
                    end
                end
            endcase
        endfunction

        function void note_request(logic func, logic [7:0] cmd);
            siren_result_t want;
            mode_t         chosen;
            if (func == FUNC_TICK) begin
                advance_tick();
            end else if (cmd == CMD_STOP || cmd == CMD_SWEEP || cmd == CMD_ALTERNATE) begin
                case (cmd)
                    CMD_STOP:  chosen = MODE_STOPPED;
                    CMD_SWEEP: chosen = MODE_SWEEP;
                    default:   chosen = MODE_ALTERNATE;
                endcase
                if (phase == PH_IDLE) begin
                    sel_mode = chosen;
                    begin_pattern();
                end else begin
                    held_mode  = chosen;
                    held_valid = 1'b1;
                end
            end
            want.active_mode  = sel_mode;
            want.second_light = lights[1];
            want.first_light  = lights[0];
            want.tone_hz      = tone;
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [15:0] data);
            siren_result_t got;
            siren_result_t want;
            got = data;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result tone %0d lights %b%b mode %0d",
                             got.tone_hz, got.second_light, got.first_light, got.active_mode);
                return;
            end
            want = expected_q.pop_front();
            if (got.tone_hz !== want.tone_hz || got.first_light !== want.first_light ||
                got.second_light !== want.second_light ||
                got.active_mode !== want.active_mode) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected tone %0d lights %b%b mode %0d, %s",
                             want.tone_hz, want.second_light, want.first_light,
                             want.active_mode,
                             $sformatf("got tone %0d lights %b%b mode %0d", got.tone_hz,
                                       got.second_light, got.first_light, got.active_mode));
            end
        endfunction
    endclass

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_tvalid     = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata      = '0;
    logic        s_tuser      = FUNC_TICK;
    logic        m_tvalid;
    logic        m_tready     = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wr_en    = 1'b0;
    cfg_idx_t    cfg_wr_index = CFG_SWEEP_LOW;
    cfg_data_t   cfg_wr_data  = '0;

    siren_scoreboard sb;
    int unsigned     items_sent     = 0;
    int unsigned     src_gap_pct    = 9;
    int unsigned     sink_stall_pct = 69;
    int unsigned     quiet_cycles   = 0;

    siren_tone_and_flash_sequencer_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[siren_tone_and_flash_sequencer_core] ERROR");
        $finish;
    end

    task automatic send_item(input logic func, input logic [7:0] cmd);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        // idle pattern: sender light, then receiver light, then no gaps at all
        if (items_sent == ITEM_BUDGET / 3) begin
            src_gap_pct    = 69;
            sink_stall_pct = 9;
        end else if (items_sent == 2 * ITEM_BUDGET / 3) begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        sb.store_reg(idx, val);
    endtask

    task automatic program_all(input cfg_data_t lo, input cfg_data_t hi, input cfg_data_t step,
                               input cfg_data_t dwell, input cfg_data_t flash,
                               input cfg_data_t tone_a, input cfg_data_t tone_b,
                               input cfg_data_t alt);
        drain();
        cfg_write(CFG_SWEEP_LOW, lo);
        cfg_write(CFG_SWEEP_HIGH, hi);
        cfg_write(CFG_SWEEP_STEP, step);
        cfg_write(CFG_SWEEP_DWELL, dwell);
        cfg_write(CFG_FLASH, flash);
        cfg_write(CFG_FIRST_TONE, tone_a);
        cfg_write(CFG_SECOND_TONE, tone_b);
        cfg_write(CFG_ALTERNATE, alt);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly ticks so patterns run to completion, with mode commands and stray bytes
    task automatic random_items(input int unsigned count);
        int unsigned roll;
        int unsigned pick;
        repeat (count) begin
            roll = $urandom_range(99);
            pick = $urandom_range(9);
            if (roll < 82)
                send_item(FUNC_TICK, 8'($urandom));
            else if (roll < 96)
                send_item(FUNC_COMMAND, (pick < 2) ? CMD_STOP :
                                        (pick < 6) ? CMD_SWEEP : CMD_ALTERNATE);
            else
                send_item(FUNC_COMMAND, 8'($urandom));
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle behaviour, ignored bytes, then commands held while a pattern runs
        send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_TICK, CMD_SWEEP);
        send_item(FUNC_COMMAND, 8'h00);
        send_item(FUNC_COMMAND, 8'hFF);
        send_item(FUNC_COMMAND, 8'h2F);
        send_item(FUNC_COMMAND, 8'h33);
        send_item(FUNC_COMMAND, CMD_STOP);
        send_item(FUNC_COMMAND, CMD_SWEEP);
        send_item(FUNC_TICK, 8'hFF);
        send_item(FUNC_TICK, 8'h55);
        send_item(FUNC_COMMAND, CMD_ALTERNATE);
        send_item(FUNC_COMMAND, CMD_STOP);
        send_item(FUNC_COMMAND, CMD_ALTERNATE);
        send_item(FUNC_TICK, 8'hAA);
        send_item(FUNC_COMMAND, 8'h80);
        send_item(FUNC_TICK, CMD_STOP);
        random_items(104);

        // short patterns so they end, restart and pick up held commands often
        program_all(12'd100, 12'd130, 12'd10, 12'd2, 12'd3, 12'hABC, 12'h543, 12'd2);
        send_item(FUNC_COMMAND, CMD_ALTERNATE);
        repeat (3) send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_COMMAND, CMD_SWEEP);
        repeat (24) send_item(FUNC_TICK, 8'h00);
        random_items(372);

        // zero times and step, low bound above high bound
        program_all(12'd3000, 12'd2000, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0);
        random_items(300);

        // full frequency range with the largest step
        program_all(12'd0, 12'd4095, 12'd255, 12'd1, 12'd1, 12'd0, 12'd4095, 12'd1);
        random_items(300);

        // longest hold times, only the start of each pattern is reached
        program_all(12'd4095, 12'd4095, 12'd1, 12'd255, 12'd1023, 12'd4095, 12'd4095,
                    12'd1023);
        random_items(130);

        // random settings, unused upper bits of the narrow registers set at random
        repeat (3) begin
            program_all(cfg_data_t'($urandom_range(4095)), cfg_data_t'($urandom_range(4095)),
                        cfg_data_t'(($urandom_range(15) << 8) | $urandom_range(255, 64)),
                        cfg_data_t'(($urandom_range(15) << 8) | $urandom_range(2, 1)),
                        cfg_data_t'(($urandom_range(3) << 10) | $urandom_range(4, 1)),
                        cfg_data_t'($urandom_range(4095)), cfg_data_t'($urandom_range(4095)),
                        cfg_data_t'(($urandom_range(3) << 10) | $urandom_range(4, 1)));
            random_items(118);
        end

        drain();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("[siren_tone_and_flash_sequencer_core] OK");
        else
            $display("[siren_tone_and_flash_sequencer_core] ERROR");
        $finish;
    end
endmodule
